// File: rtl/flcg_pkg.sv
// Shared types and constants for the servo fault latch and command guard.
package flcg_pkg;

    // Request function selector
    typedef enum logic [1:0] {
        FUNC_REPORT = 2'd0,
        FUNC_EXIT   = 2'd1,
        FUNC_FILTER = 2'd2
    } func_t;

    // Fault and status codes
    typedef enum logic [2:0] {
        FAULT_SUCCESS = 3'd0,
        FAULT_EXCEED  = 3'd1,
        FAULT_BEHIND  = 3'd2,
        FAULT_VEL     = 3'd3,
        FAULT_TORQUE  = 3'd4,
        FAULT_SIGNAL  = 3'd5,
        FAULT_TEMP    = 3'd6,
        FAULT_OTHER   = 3'd7
    } fault_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SAFETY_ENABLED = 2'd0,
        CFG_POSITION_MAX   = 2'd1,
        CFG_POSITION_MIN   = 2'd2
    } cfg_index_t;

    localparam int FLAG_COUNT = 6;

    typedef logic [FLAG_COUNT-1:0] flags_t;

    // Latch positions in the fault flag word
    localparam int FLAG_EXCEED = 0;
    localparam int FLAG_BEHIND = 1;
    localparam int FLAG_VEL    = 2;
    localparam int FLAG_TORQUE = 3;
    localparam int FLAG_SIGNAL = 4;
    localparam int FLAG_TEMP   = 5;

    // Map a fault code to its latch bit; success and other map to nothing
    function automatic flags_t fault_mask(fault_t code);
        flags_t mask;
        mask = '0;
        case (code)
            FAULT_EXCEED: mask[FLAG_EXCEED] = 1'b1;
            FAULT_BEHIND: mask[FLAG_BEHIND] = 1'b1;
            FAULT_VEL:    mask[FLAG_VEL]    = 1'b1;
            FAULT_TORQUE: mask[FLAG_TORQUE] = 1'b1;
            FAULT_SIGNAL: mask[FLAG_SIGNAL] = 1'b1;
            FAULT_TEMP:   mask[FLAG_TEMP]   = 1'b1;
            default:      mask = '0;
        endcase
        return mask;
    endfunction

endpackage

// File: rtl/fault_latch_command_guard_core.sv
// Servo fault latch and command guard: fault latches, hold anchor and command filter.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: func, fault_code,
//   servo_position, servo_lagging and command_position. A request is taken at
//   a rising edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   request: status_code and safe_position, in request order.
//   A request is first held in an input register; then the fault latches
//   update and the result is loaded into the output register.
//   Throughput: one request per cycle while out_stall is low; the path from
//   the input register through the latch update and clamp compare to the
//   output register sets it.
//   When the receiver stalls, the output register holds its result; the input
//   register still takes one more request, then in_stall rises until the
//   output drains.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the next
//   edge. The user must make them only while no request is in flight; not checked.
//   Reset clears the fault latches and hold anchor, enables safety and loads
//   the default position limits; both channels come up empty.
module fault_latch_command_guard_core #(
    parameter int POSITION_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_write,
    input  logic [1:0]                      cfg_index,
    input  logic [POSITION_BITS-1:0]        cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      func,
    input  logic [2:0]                      fault_code,
    input  logic signed [POSITION_BITS-1:0] servo_position,
    input  logic                            servo_lagging,
    input  logic signed [POSITION_BITS-1:0] command_position,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      status_code,
    output logic signed [POSITION_BITS-1:0] safe_position
);

    localparam logic [POSITION_BITS-1:0] POS_MAX_RESET = POSITION_BITS'(32'sd16384);
    localparam logic [POSITION_BITS-1:0] POS_MIN_RESET = POSITION_BITS'(-32'sd16384);

    // Configuration registers
    logic                            safety_enabled_reg;
    logic signed [POSITION_BITS-1:0] position_max_reg;
    logic signed [POSITION_BITS-1:0] position_min_reg;

    // Input stage
    logic                            s1_valid_reg;
    flcg_pkg::func_t                 s1_func_reg;
    flcg_pkg::fault_t                s1_code_reg;
    logic signed [POSITION_BITS-1:0] s1_servo_reg;
    logic                            s1_lag_reg;
    logic signed [POSITION_BITS-1:0] s1_cmd_reg;

    // Block state
    flcg_pkg::flags_t                flags_reg;
    flcg_pkg::flags_t                flags_next;
    logic signed [POSITION_BITS-1:0] hold_position_reg;
    logic signed [POSITION_BITS-1:0] hold_position_next;

    // Output stage
    logic                            out_valid_reg;
    logic [2:0]                      status_reg;
    logic [2:0]                      status_next;
    logic signed [POSITION_BITS-1:0] safe_position_reg;
    logic signed [POSITION_BITS-1:0] safe_position_next;

    logic out_open;
    logic fire;
    logic in_take;
    logic behind_hit;
    logic above_max;
    logic below_min;

    // Handshake: output opens when empty or drained; input waits on a full stage
    assign out_open = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && out_open;
    assign in_stall = s1_valid_reg && !out_open;
    assign in_take  = in_valid && !in_stall;

    assign out_valid     = out_valid_reg;
    assign status_code   = status_reg;
    assign safe_position = safe_position_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safety_enabled_reg <= 1'b1;
            position_max_reg   <= POS_MAX_RESET;
            position_min_reg   <= POS_MIN_RESET;
        end
        else if (cfg_write)
        begin
            case (flcg_pkg::cfg_index_t'(cfg_index))
                flcg_pkg::CFG_SAFETY_ENABLED: safety_enabled_reg <= cfg_data[0];
                flcg_pkg::CFG_POSITION_MAX:   position_max_reg   <= cfg_data;
                flcg_pkg::CFG_POSITION_MIN:   position_min_reg   <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // Hold the input stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_func_reg  <= flcg_pkg::func_t'(func);
            s1_code_reg  <= flcg_pkg::fault_t'(fault_code);
            s1_servo_reg <= servo_position;
            s1_lag_reg   <= servo_lagging;
            s1_cmd_reg   <= command_position;
        end
    end

    // Detect a position-behind event and compare the command to the limits
    assign behind_hit = (s1_code_reg == flcg_pkg::FAULT_BEHIND)
                     || (s1_lag_reg && ((s1_code_reg == flcg_pkg::FAULT_TORQUE)
                                     || (s1_code_reg == flcg_pkg::FAULT_TEMP)));
    assign above_max  = s1_cmd_reg > position_max_reg;
    assign below_min  = s1_cmd_reg < position_min_reg;

    // Compute latch update and result for the request in the input stage
    always_comb
    begin
        flags_next         = flags_reg;
        hold_position_next = hold_position_reg;
        status_next        = flcg_pkg::FAULT_SUCCESS;
        safe_position_next = '0;
        case (s1_func_reg)
            flcg_pkg::FUNC_REPORT:
            begin
                status_next = s1_code_reg;
                if (safety_enabled_reg)
                begin
                    flags_next = flags_reg | flcg_pkg::fault_mask(s1_code_reg);
                    if (behind_hit)
                    begin
                        flags_next[flcg_pkg::FLAG_BEHIND] = 1'b1;
                        if (!flags_reg[flcg_pkg::FLAG_BEHIND])
                        begin
                            hold_position_next = s1_servo_reg;
                        end
                    end
                    if ((s1_code_reg == flcg_pkg::FAULT_EXCEED)
                        || (s1_code_reg == flcg_pkg::FAULT_BEHIND))
                    begin
                        status_next = flcg_pkg::FAULT_SUCCESS;
                    end
                end
            end
            flcg_pkg::FUNC_EXIT:
            begin
                if (safety_enabled_reg)
                begin
                    flags_next = flags_reg & ~flcg_pkg::fault_mask(s1_code_reg);
                end
            end
            flcg_pkg::FUNC_FILTER:
            begin
                safe_position_next = s1_cmd_reg;
                if (safety_enabled_reg)
                begin
                    if (flags_reg[flcg_pkg::FLAG_EXCEED] && above_max)
                    begin
                        safe_position_next = position_max_reg;
                    end
                    else if (flags_reg[flcg_pkg::FLAG_EXCEED] && below_min)
                    begin
                        safe_position_next = position_min_reg;
                    end
                    else if (flags_reg[flcg_pkg::FLAG_BEHIND])
                    begin
                        safe_position_next = hold_position_reg;
                    end
                end
            end
            default:
            begin
                status_next        = flcg_pkg::FAULT_SUCCESS;
                safe_position_next = '0;
            end
        endcase
    end

    // Advance the fault latches and hold anchor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg         <= '0;
            hold_position_reg <= '0;
        end
        else if (fire)
        begin
            flags_reg         <= flags_next;
            hold_position_reg <= hold_position_next;
        end
    end

    // Hold the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_open)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Load the result
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg        <= status_next;
            safe_position_reg <= safe_position_next;
        end
    end

    // An enabled exceed report leaves the exceed latch set
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && safety_enabled_reg && (s1_func_reg == flcg_pkg::FUNC_REPORT)
            && (s1_code_reg == flcg_pkg::FAULT_EXCEED)
        |=> flags_reg[flcg_pkg::FLAG_EXCEED])
        else $error("exceed latch not set by exceed report");

    // The hold anchor moves only when the behind latch goes from clear to set
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(hold_position_reg) |-> $rose(flags_reg[flcg_pkg::FLAG_BEHIND]))
        else $error("hold anchor changed without behind latch rising");

    // A result leaves the output register only when it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(!out_stall))
        else $error("result dropped while stalled");

    // Input stalls only with a request waiting in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with room to advance");

endmodule
